// ----- sv/tcw_pkg.sv -----
// ============================================================================
// tcw_pkg: shared definitions for the text console character writer
// Field widths, character codes, command codes, defaults and the FSM type.
// ============================================================================
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CMD_W    = 1;
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int ATTR_W   = 8;

  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_NUL      = 8'd0;
  localparam logic [CHAR_W-1:0] CH_LINEFEED = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN   = 8'd13;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_FLUSH  = 5'b10000
  } tcw_state_t;

endpackage

// ----- sv/tcw_ram.sv -----
// ============================================================================
// tcw_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/text_console_char_writer_core.sv -----
// ============================================================================
// text_console_char_writer_core: text-mode console cell store and cursor
// Puts characters at a linear cursor, scrolls the screen up by one row when
// the cursor runs off the end, and reads back single cells.
// ============================================================================
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | in_cmd, in_char_code, in_read_index
//  result   | out_valid (strobe) | out_cursor_pos, out_cell_value,
//           |                    | out_scrolled
//  config   | cfg_we             | cfg_wdata (text attribute)
//
//  A put without scroll leaves busy low; its result shows in the next cycle.
//  A read passes S_READ, which takes the registered RAM data, and its result
//  is registered. A scrolling put walks the cell RAM one cell a cycle.
//  After reset a clearing pass over all ROWS*COLUMNS cells holds busy high.
//  Each result is present for exactly one cycle; the receiver cannot stall.
//
module text_console_char_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcw_pkg::CMD_W-1:0]     in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::IDX_W-1:0]     in_read_index,
  output logic                          out_valid,
  output logic [tcw_pkg::CURSOR_W-1:0]  out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]    out_cell_value,
  output logic                          out_scrolled,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata
);

  import tcw_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CUR_W  = $clog2(CELLS + COLUMNS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [CUR_W-1:0]  CUR_CELLS    = CUR_W'(CELLS);
  localparam logic [CUR_W-1:0]  CUR_COLUMNS  = CUR_W'(COLUMNS);
  localparam logic [CUR_W-1:0]  CUR_LAST_ROW = CUR_W'(CELLS - COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ADDR_BLANK   = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ADDR_COLUMNS = ADDR_W'(COLUMNS);

  tcw_state_t state_r, state_nxt;

  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [CUR_W-1:0]    cursor_r, cursor_nxt;
  logic [CUR_W-1:0]    row_base_r, row_base_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ATTR_W-1:0]   attr_r, attr_nxt;
  logic                rd_oob_r, rd_oob_nxt;

  logic                pend_valid_r, pend_valid_nxt;
  logic                pend_blank_r, pend_blank_nxt;
  logic [ADDR_W-1:0]   pend_addr_r, pend_addr_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [CURSOR_W-1:0] out_cursor_r, out_cursor_nxt;
  logic [CELL_W-1:0]   out_cell_r, out_cell_nxt;
  logic                out_scrolled_r, out_scrolled_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic                accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic [CUR_W-1:0] cur_n;
    logic [CUR_W-1:0] rb_n;
    logic [COL_W-1:0] col_n;

    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    cursor_nxt       = cursor_r;
    row_base_nxt     = row_base_r;
    col_nxt          = col_r;
    attr_nxt         = cfg_we ? cfg_wdata : attr_r;
    rd_oob_nxt       = rd_oob_r;
    pend_valid_nxt   = 1'b0;
    pend_blank_nxt   = pend_blank_r;
    pend_addr_nxt    = pend_addr_r;
    out_valid_nxt    = 1'b0;
    out_cursor_nxt   = out_cursor_r;
    out_cell_nxt     = out_cell_r;
    out_scrolled_nxt = out_scrolled_r;
    ram_we           = 1'b0;
    ram_waddr        = cnt_r;
    ram_wdata        = '0;
    ram_raddr        = ADDR_W'(in_read_index);
    cur_n            = cursor_r;
    rb_n             = row_base_r;
    col_n            = col_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = '0;
        cnt_nxt   = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_READ) begin
            rd_oob_nxt = (32'(in_read_index) >= 32'(CELLS));
            state_nxt  = S_READ;
          end else begin
            priority if (in_char_code == CH_RETURN) begin
              cur_n = row_base_r;
              col_n = '0;
            end else if (in_char_code == CH_LINEFEED) begin
              cur_n = cursor_r + CUR_COLUMNS;
              rb_n  = row_base_r + CUR_COLUMNS;
            end else if (in_char_code != CH_NUL) begin
              // The cursor is always on screen here, so the write is in range.
              ram_we    = 1'b1;
              ram_waddr = cursor_r[ADDR_W-1:0];
              ram_wdata = {attr_r, in_char_code};
              cur_n     = cursor_r + CUR_W'(1);
              if (col_r == COL_LAST) begin
                col_n = '0;
                rb_n  = row_base_r + CUR_COLUMNS;
              end else begin
                col_n = col_r + COL_W'(1);
              end
            end else begin
              cur_n = cursor_r;
            end
            out_cell_nxt = '0;
            if (cur_n >= CUR_CELLS) begin
              cursor_nxt   = CUR_LAST_ROW;
              row_base_nxt = CUR_LAST_ROW;
              col_nxt      = '0;
              cnt_nxt      = '0;
              state_nxt    = S_SCROLL;
            end else begin
              cursor_nxt       = cur_n;
              row_base_nxt     = rb_n;
              col_nxt          = col_n;
              out_valid_nxt    = 1'b1;
              out_cursor_nxt   = CURSOR_W'(cur_n);
              out_scrolled_nxt = 1'b0;
            end
          end
        end
      end

      S_READ: begin
        out_valid_nxt    = 1'b1;
        out_cursor_nxt   = CURSOR_W'(cursor_r);
        out_cell_nxt     = rd_oob_r ? '0 : ram_rdata;
        out_scrolled_nxt = 1'b0;
        state_nxt        = S_IDLE;
      end

      S_SCROLL: begin
        // Reads run ahead of the writes they feed through the pend registers;
        // the bottom row goes through the same write slot with blank data.
        ram_raddr      = cnt_r + ADDR_COLUMNS;
        pend_valid_nxt = 1'b1;
        pend_addr_nxt  = cnt_r;
        pend_blank_nxt = (cnt_r >= ADDR_BLANK);
        ram_we         = pend_valid_r;
        ram_waddr      = pend_addr_r;
        ram_wdata      = pend_blank_r ? '0 : ram_rdata;
        cnt_nxt        = cnt_r + ADDR_W'(1);
        if (cnt_r == ADDR_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FLUSH;
        end
      end

      S_FLUSH: begin
        ram_we           = pend_valid_r;
        ram_waddr        = pend_addr_r;
        ram_wdata        = pend_blank_r ? '0 : ram_rdata;
        out_valid_nxt    = 1'b1;
        out_cursor_nxt   = CURSOR_W'(cursor_r);
        out_scrolled_nxt = 1'b1;
        state_nxt        = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      cursor_r     <= '0;
      row_base_r   <= '0;
      col_r        <= '0;
      attr_r       <= ATTR_RESET;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cursor_r     <= cursor_nxt;
      row_base_r   <= row_base_nxt;
      col_r        <= col_nxt;
      attr_r       <= attr_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_oob_r       <= rd_oob_nxt;
    pend_blank_r   <= pend_blank_nxt;
    pend_addr_r    <= pend_addr_nxt;
    out_cursor_r   <= out_cursor_nxt;
    out_cell_r     <= out_cell_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_cursor_r;
  assign out_cell_value = out_cell_r;
  assign out_scrolled   = out_scrolled_r;

`ifndef SYNTHESIS
  // The row start plus the column always gives the linear cursor.
  a_cursor_split: assert property (@(posedge clk) disable iff (!rst_n)
    (row_base_r + CUR_W'(col_r)) == cursor_r)
    else $error("cursor is not row base plus column");

  // Outside a scroll the cursor stays on screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cursor_r < CUR_CELLS))
    else $error("cursor off screen while idle");

  // A scrolled result leaves the cursor at the start of the bottom row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scrolled_r) |-> (cursor_r == CUR_LAST_ROW))
    else $error("scroll left cursor off the bottom row start");

  // An accepted read delivers its result through S_READ and the output register.
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_READ) |=> ##1 (out_valid_r && !out_scrolled_r))
    else $error("read result missing");
`endif

endmodule
